// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define JEF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define JEF_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/jef_pkg.sv =====
package jef_pkg;

   // Offsets inside the file can reach a 32-bit IFD offset plus the TIFF base.
   localparam int OFF_W = 34;

   localparam logic [7:0]  MARK_PREFIX    = 8'hFF;
   localparam logic [7:0]  MARK_SOS       = 8'hDA;
   localparam logic [7:0]  MARK_EOI       = 8'hD9;
   localparam logic [7:0]  MARK_APP1      = 8'hE1;
   localparam logic [15:0] SOI_WORD       = 16'hFFD8;
   localparam logic [15:0] SEG_LEN_MIN    = 16'd2;
   // Length field counts itself, so 14 payload bytes need a length of 16.
   localparam logic [15:0] APP1_LEN_MIN   = 16'd16;
   localparam logic [31:0] EXIF_HEAD      = 32'h45786966;
   localparam logic [15:0] EXIF_PAD       = 16'h0000;
   localparam logic [15:0] BO_LITTLE      = 16'h4949;
   localparam logic [15:0] BO_BIG         = 16'h4D4D;
   localparam logic [15:0] TIFF_MAGIC     = 16'd42;
   localparam logic [15:0] ORIENT_TAG     = 16'h0112;
   localparam logic [15:0] TYPE_SHORT     = 16'd3;
   localparam logic [31:0] ORIENT_COUNT   = 32'd1;
   localparam logic [3:0]  ORIENT_DEFAULT = 4'd1;
   localparam int          ENTRY_BYTES    = 12;

   typedef enum logic [4:0] {
      W_IDLE,
      W_SOI,
      W_SOI_CHK,
      W_MARK,
      W_MARK_CHK,
      W_LEN_CHK,
      W_EXIF_A,
      W_EXIF_B,
      W_BO,
      W_MAGIC,
      W_IFD,
      W_CNT,
      W_ENT,
      W_TAG,
      W_TYPE,
      W_COUNT1,
      W_VAL,
      W_RD_ADDR,
      W_RD_DATA,
      W_DONE
   } walk_state_type;

   typedef struct packed {
      logic rd_en;
      logic busy;
   } back_ctl_type;

endpackage

// ===== hw/rtl/jef_front.sv =====
module jef_front
   import jef_pkg::*;
#(
   parameter int STORE_DEPTH = 65536,
   parameter int CNT_W       = 17,
   parameter int ADDR_W      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  back_ctl_type      back_ctl,
   input  logic              job_waiting,
   output logic              job_push,
   output logic [CNT_W-1:0]  job_size,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0]       mem [STORE_DEPTH];
   logic [CNT_W-1:0] held_ff, held_in;
   logic [7:0]       rd_data_ff;
   logic             accept;
   logic             room;

   // The store holds one file, so loading waits until the walk of the last one ends.
   assign req_ready = !(back_ctl.busy || job_waiting);
   assign accept    = req_valid && req_ready;
   assign room      = held_ff < CNT_W'(STORE_DEPTH);
   assign job_push  = accept && req_last_byte;
   assign job_size  = held_ff + CNT_W'(room);
   assign rd_data   = rd_data_ff;

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         if (req_last_byte) begin
            held_in = '0;
         end else begin
            held_in = held_ff + CNT_W'(room);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         mem[held_ff[ADDR_W-1:0]] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (back_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/jef_queue.sv =====
module jef_queue
   import jef_pkg::*;
#(
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign not_empty = count_ff != 2'd0;
   assign head_data = data_ff[rd_ptr_ff];
   assign do_push   = push && (count_ff != 2'd2);
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/jef_back.sv =====
module jef_back
   import jef_pkg::*;
#(
   parameter int CNT_W  = 17,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  logic [CNT_W-1:0]  job_size,
   output logic              job_pop,
   output back_ctl_type      back_ctl,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_orientation_code
);

   walk_state_type   state_ff, state_in;
   walk_state_type   ret_ff, ret_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [OFF_W-1:0] pos_ff, pos_in;
   logic [OFF_W-1:0] tiff_ff, tiff_in;
   logic [OFF_W-1:0] entry_ff, entry_in;
   logic [OFF_W-1:0] cur_ff, cur_in;
   logic [7:0]       kind_ff, kind_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      ent_left_ff, ent_left_in;
   logic             little_ff, little_in;
   logic             le_ff, le_in;
   logic [2:0]       nleft_ff, nleft_in;
   logic [1:0]       k_ff, k_in;
   logic [31:0]      val_ff, val_in;
   logic [3:0]       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_code_ff, rsp_code_in;

   logic             fr_req;
   logic [OFF_W-1:0] fr_off;
   logic [2:0]       fr_n;
   logic             fr_le;
   walk_state_type   fr_ret;
   logic             fr_oob;

   logic [OFF_W-1:0] size_o;
   logic [15:0]      len_sel;
   logic [OFF_W-1:0] seg_next;
   logic [OFF_W-1:0] ifd_off;
   logic             mark_room;
   logic             mark_ok;
   logic             len_bad;
   logic             exif_try;
   logic             bo_ok;
   logic             bo_little;
   logic             ifd_bad;
   logic             entry_bad;
   logic             out_free;

   assign size_o    = OFF_W'(size_ff);
   assign len_sel   = (state_ff == W_LEN_CHK) ? val_ff[15:0] : len_ff;
   assign seg_next  = pos_ff + OFF_W'(2) + OFF_W'(len_sel);
   assign ifd_off   = tiff_ff + OFF_W'(val_ff);
   assign mark_room = (pos_ff + OFF_W'(4)) <= size_o;
   assign mark_ok   = (val_ff[15:8] == MARK_PREFIX) && (val_ff[7:0] != MARK_SOS)
                      && (val_ff[7:0] != MARK_EOI);
   assign len_bad   = (len_sel < SEG_LEN_MIN) || (seg_next > size_o);
   assign exif_try  = (kind_ff == MARK_APP1) && (val_ff[15:0] >= APP1_LEN_MIN);
   assign bo_little = val_ff[15:0] == BO_LITTLE;
   assign bo_ok     = bo_little || (val_ff[15:0] == BO_BIG);
   assign ifd_bad   = (ifd_off + OFF_W'(2)) > size_o;
   assign entry_bad = (entry_ff + OFF_W'(ENTRY_BYTES)) > size_o;
   assign fr_oob    = (fr_off + OFF_W'(fr_n)) > size_o;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign job_pop              = (state_ff == W_IDLE) && job_valid;
   assign back_ctl.busy        = state_ff != W_IDLE;
   assign back_ctl.rd_en       = state_ff == W_RD_ADDR;
   assign rd_addr              = cur_ff[ADDR_W-1:0];
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_orientation_code = rsp_code_ff;

   // Each parse step that needs a field of the file asks for a read of 2 or 4 bytes.
   always_comb begin
      fr_req = 1'b0;
      fr_off = '0;
      fr_n   = 3'd2;
      fr_le  = 1'b0;
      fr_ret = W_IDLE;
      case (state_ff)
         W_SOI: begin
            fr_req = 1'b1;
            fr_ret = W_SOI_CHK;
         end
         W_MARK: begin
            fr_req = mark_room;
            fr_off = pos_ff;
            fr_ret = W_MARK_CHK;
         end
         W_MARK_CHK: begin
            fr_req = mark_ok;
            fr_off = pos_ff + OFF_W'(2);
            fr_ret = W_LEN_CHK;
         end
         W_LEN_CHK: begin
            fr_req = !len_bad && exif_try;
            fr_off = pos_ff + OFF_W'(4);
            fr_n   = 3'd4;
            fr_ret = W_EXIF_A;
         end
         W_EXIF_A: begin
            fr_req = val_ff == EXIF_HEAD;
            fr_off = pos_ff + OFF_W'(8);
            fr_ret = W_EXIF_B;
         end
         W_EXIF_B: begin
            fr_req = val_ff[15:0] == EXIF_PAD;
            fr_off = pos_ff + OFF_W'(10);
            fr_ret = W_BO;
         end
         W_BO: begin
            fr_req = bo_ok;
            fr_off = tiff_ff + OFF_W'(2);
            fr_le  = bo_little;
            fr_ret = W_MAGIC;
         end
         W_MAGIC: begin
            fr_req = val_ff[15:0] == TIFF_MAGIC;
            fr_off = tiff_ff + OFF_W'(4);
            fr_n   = 3'd4;
            fr_le  = little_ff;
            fr_ret = W_IFD;
         end
         W_IFD: begin
            fr_req = !ifd_bad;
            fr_off = ifd_off;
            fr_le  = little_ff;
            fr_ret = W_CNT;
         end
         W_ENT: begin
            fr_req = (ent_left_ff != 16'd0) && !entry_bad;
            fr_off = entry_ff;
            fr_le  = little_ff;
            fr_ret = W_TAG;
         end
         W_TAG: begin
            fr_req = val_ff[15:0] == ORIENT_TAG;
            fr_off = entry_ff + OFF_W'(2);
            fr_le  = little_ff;
            fr_ret = W_TYPE;
         end
         W_TYPE: begin
            fr_req = val_ff[15:0] == TYPE_SHORT;
            fr_off = entry_ff + OFF_W'(4);
            fr_n   = 3'd4;
            fr_le  = little_ff;
            fr_ret = W_COUNT1;
         end
         W_COUNT1: begin
            fr_req = val_ff == ORIENT_COUNT;
            fr_off = entry_ff + OFF_W'(8);
            fr_le  = little_ff;
            fr_ret = W_VAL;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (job_valid) begin
               state_in = (job_size < CNT_W'(4)) ? W_DONE : W_SOI;
            end
         end
         W_SOI_CHK:  state_in = (val_ff[15:0] == SOI_WORD) ? W_MARK : W_DONE;
         W_MARK:     state_in = W_DONE;
         W_MARK_CHK: state_in = W_DONE;
         W_LEN_CHK:  state_in = len_bad ? W_DONE : W_MARK;
         W_EXIF_A:   state_in = W_MARK;
         W_EXIF_B:   state_in = W_MARK;
         W_BO:       state_in = W_DONE;
         W_MAGIC:    state_in = W_DONE;
         W_IFD:      state_in = W_DONE;
         W_CNT:      state_in = W_ENT;
         W_ENT:      state_in = W_DONE;
         W_TAG:      state_in = W_ENT;
         W_TYPE:     state_in = W_ENT;
         W_COUNT1:   state_in = W_ENT;
         W_VAL:      state_in = W_DONE;
         W_RD_ADDR:  state_in = W_RD_DATA;
         W_RD_DATA:  state_in = (nleft_ff == 3'd1) ? ret_ff : W_RD_ADDR;
         W_DONE: begin
            if (out_free) begin
               state_in = W_IDLE;
            end
         end
         default:    state_in = W_IDLE;
      endcase
      if (fr_req) begin
         // A read that runs past the held bytes yields zero without touching the store.
         state_in = fr_oob ? fr_ret : W_RD_ADDR;
      end
   end

   always_comb begin
      ret_in       = ret_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      tiff_in      = tiff_ff;
      entry_in     = entry_ff;
      cur_in       = cur_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      ent_left_in  = ent_left_ff;
      little_in    = little_ff;
      le_in        = le_ff;
      nleft_in     = nleft_ff;
      k_in         = k_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      case (state_ff)
         W_IDLE: begin
            if (job_valid) begin
               size_in = job_size;
               pos_in  = OFF_W'(2);
               res_in  = ORIENT_DEFAULT;
            end
         end
         W_MARK_CHK: kind_in = val_ff[7:0];
         W_LEN_CHK: begin
            len_in = val_ff[15:0];
            if (!len_bad && !exif_try) begin
               pos_in = seg_next;
            end
         end
         W_EXIF_A: begin
            if (val_ff != EXIF_HEAD) begin
               pos_in = seg_next;
            end
         end
         W_EXIF_B: begin
            if (val_ff[15:0] == EXIF_PAD) begin
               tiff_in = pos_ff + OFF_W'(10);
            end else begin
               pos_in = seg_next;
            end
         end
         W_BO:  little_in = bo_little;
         W_IFD: entry_in = ifd_off + OFF_W'(2);
         W_CNT: ent_left_in = val_ff[15:0];
         W_TAG, W_TYPE, W_COUNT1: begin
            if (!fr_req) begin
               entry_in    = entry_ff + OFF_W'(ENTRY_BYTES);
               ent_left_in = ent_left_ff - 16'd1;
            end
         end
         W_VAL: begin
            if (val_ff[15:0] inside {[16'd1:16'd8]}) begin
               res_in = val_ff[3:0];
            end
         end
         W_RD_DATA: begin
            if (le_ff) begin
               val_in = val_ff | (32'(rd_data) << {k_ff, 3'b000});
            end else begin
               val_in = {val_ff[23:0], rd_data};
            end
            cur_in   = cur_ff + OFF_W'(1);
            nleft_in = nleft_ff - 3'd1;
            k_in     = k_ff + 2'd1;
         end
         W_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
      if (fr_req) begin
         cur_in   = fr_off;
         nleft_in = fr_n;
         k_in     = 2'd0;
         val_in   = '0;
         le_in    = fr_le;
         ret_in   = fr_ret;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      size_ff     <= size_in;
      pos_ff      <= pos_in;
      tiff_ff     <= tiff_in;
      entry_ff    <= entry_in;
      cur_ff      <= cur_in;
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      ent_left_ff <= ent_left_in;
      little_ff   <= little_in;
      le_ff       <= le_in;
      nleft_ff    <= nleft_in;
      k_ff        <= k_in;
      val_ff      <= val_in;
      res_ff      <= res_in;
      rsp_code_ff <= rsp_code_in;
   end

endmodule

// ===== hw/rtl/jpeg_exif_orientation_finder_core.sv =====
// Loading: one byte word per cycle while ready; the file is held in a single-port-read byte store.
// Walk: after the last byte the header walk runs, reading each byte from the store in W_RD_ADDR
// then W_RD_DATA, so its length scales with the marker segments and IFD0 entries walked.
// Throughput: the next file is taken once the walk of the current one has finished.
// Reset: synchronous; clears the byte count, the job queue, the walker and the result valid.
// The byte store is not cleared and needs no clearing pass.
module jpeg_exif_orientation_finder_core
   import jef_pkg::*;
#(
   parameter int STORE_DEPTH = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_orientation_code
);

   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   back_ctl_type      back_ctl;
   logic              job_push;
   logic [CNT_W-1:0]  job_size;
   logic              job_pop;
   logic              job_valid;
   logic [CNT_W-1:0]  job_head;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   jef_front #(
      .STORE_DEPTH (STORE_DEPTH),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .back_ctl      (back_ctl),
      .job_waiting   (job_valid),
      .job_push      (job_push),
      .job_size      (job_size),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   jef_queue #(
      .WIDTH (CNT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_size),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_data (job_head)
   );

   jef_back #(
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (job_valid),
      .job_size             (job_head),
      .job_pop              (job_pop),
      .back_ctl             (back_ctl),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_orientation_code (rsp_orientation_code)
   );

endmodule

// ===== hw/rtl/jef_checker.sv =====
`include "assert_macros.svh"

module jef_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_code
);

   logic code_ok;
   logic last_taken;
   logic rsp_stall;

   assign code_ok    = (rsp_code >= 4'd1) && (rsp_code <= 4'd8);
   assign last_taken = req_valid && req_ready && req_last_byte;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   // Coming out of reset nothing is pending and the loader is open.
   `JEF_ASSERT_NR(a_reset_quiet, clock, reset |=> (!rsp_valid && req_ready), "busy after reset")

   `JEF_ASSERT(a_code_range, clock, reset, rsp_valid |-> code_ok, "orientation out of range")

   // The store holds one file, so the loader must close right after a last byte.
   `JEF_ASSERT(a_last_closes, clock, reset, last_taken |=> !req_ready, "loader open during walk")

   `JEF_ASSERT(a_hold_valid, clock, reset, rsp_stall |=> rsp_valid, "stalled result dropped")

   `JEF_ASSERT(a_hold_code, clock, reset, rsp_stall |=> $stable(rsp_code), "result changed")

endmodule

bind jpeg_exif_orientation_finder_core jef_checker u_jef_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code      (rsp_orientation_code)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
   import jef_pkg::*;
;

   localparam int STORE_BYTES  = 128;
   localparam int TOTAL_WORDS  = 850;
   localparam int RANDOM_FILES = 3;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 10;
   localparam int TAIL_CYCLES  = 300;
   localparam int TIMEOUT_NS   = 10_000_000;
   localparam int IFD_NEAR     = 8;
   localparam int BIG_SEG      = 80;
   localparam int ORIENT_MAX   = 8;
   localparam logic [7:0] MARK_APP0  = 8'hE0;
   localparam logic [7:0] MARK_APP15 = 8'hEF;
   // Marks a stimulus row whose expected code comes from the predictor.
   localparam logic [3:0] USE_MODEL  = 4'd0;

   typedef enum logic [3:0] {
      F_ONE_BYTE,
      F_SHORT,
      F_EOI_ONLY,
      F_NO_SOI,
      F_LEN_SMALL,
      F_LEN_LONG,
      F_NOT_MARKER,
      F_SOS_FIRST,
      F_EXIF,
      F_FILLER,
      F_APP1_PLAIN,
      F_APP1_SHORT,
      F_STORE_FULL
   } shape_type;

   typedef enum logic [3:0] {
      T_NONE,
      T_BIG,
      T_ORDER,
      T_MAGIC,
      T_IFD_FAR,
      T_ENTRY_CUT,
      T_TYPE,
      T_COUNT,
      T_OTHERS
   } tweak_type;

   typedef struct packed {
      shape_type   shape;
      tweak_type   tweak;
      logic [15:0] orient;
      logic [3:0]  typed;
   } plan_row_type;

   typedef struct {
      logic [15:0] order;
      logic [15:0] magic;
      logic [31:0] ifd_off;
      int          n_other;
      logic [15:0] n_ent;
      logic [15:0] tag;
      logic [15:0] tag_kind;
      logic [31:0] tag_count;
      logic [15:0] orient;
   } exif_spec_type;

   localparam plan_row_type PLAN [0:24] = '{
      '{F_ONE_BYTE,   T_NONE,      16'd0,     ORIENT_DEFAULT},
      '{F_SHORT,      T_NONE,      16'd0,     ORIENT_DEFAULT},
      '{F_EOI_ONLY,   T_NONE,      16'd0,     ORIENT_DEFAULT},
      '{F_NO_SOI,     T_NONE,      16'd6,     ORIENT_DEFAULT},
      '{F_EXIF,       T_NONE,      16'd6,     4'd6},
      '{F_EXIF,       T_BIG,       16'd8,     4'd8},
      '{F_EXIF,       T_NONE,      16'd0,     ORIENT_DEFAULT},
      '{F_EXIF,       T_BIG,       16'd9,     ORIENT_DEFAULT},
      '{F_EXIF,       T_NONE,      16'hFFFF,  ORIENT_DEFAULT},
      '{F_EXIF,       T_BIG,       16'h0100,  ORIENT_DEFAULT},
      '{F_EXIF,       T_ORDER,     16'd3,     ORIENT_DEFAULT},
      '{F_EXIF,       T_MAGIC,     16'd3,     ORIENT_DEFAULT},
      '{F_EXIF,       T_IFD_FAR,   16'd3,     ORIENT_DEFAULT},
      '{F_EXIF,       T_ENTRY_CUT, 16'd3,     ORIENT_DEFAULT},
      '{F_EXIF,       T_TYPE,      16'd3,     ORIENT_DEFAULT},
      '{F_EXIF,       T_COUNT,     16'd3,     ORIENT_DEFAULT},
      '{F_LEN_SMALL,  T_NONE,      16'd5,     ORIENT_DEFAULT},
      '{F_LEN_LONG,   T_NONE,      16'd5,     ORIENT_DEFAULT},
      '{F_NOT_MARKER, T_NONE,      16'd5,     ORIENT_DEFAULT},
      '{F_SOS_FIRST,  T_NONE,      16'd5,     ORIENT_DEFAULT},
      '{F_APP1_PLAIN, T_NONE,      16'd2,     USE_MODEL},
      '{F_APP1_SHORT, T_BIG,       16'd7,     USE_MODEL},
      '{F_FILLER,     T_OTHERS,    16'd4,     USE_MODEL},
      '{F_EXIF,       T_OTHERS,    16'd5,     USE_MODEL},
      '{F_STORE_FULL, T_NONE,      16'd3,     USE_MODEL}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [3:0] rsp_orientation_code;

   // Predictor copy of the file store.
   logic [7:0]  held_bytes [STORE_BYTES];
   int unsigned held_count;

   logic [7:0] file_q [$];
   logic [3:0] orient_due [$];
   int         errors;
   int         rsp_count;

   jpeg_exif_orientation_finder_core #(
      .STORE_DEPTH(STORE_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_orientation_code(rsp_orientation_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint unsigned peek8(longint unsigned off);
      if (off >= held_count) return 0;
      return held_bytes[int'(off)];
   endfunction

   function automatic longint unsigned peek16(longint unsigned off, bit le);
      if (off + 2 > held_count) return 0;
      if (le) return peek8(off) | (peek8(off + 1) << 8);
      return (peek8(off) << 8) | peek8(off + 1);
   endfunction

   function automatic longint unsigned peek32(longint unsigned off, bit le);
      if (off + 4 > held_count) return 0;
      if (le) return peek16(off, 1'b1) | (peek16(off + 2, 1'b1) << 16);
      return (peek16(off, 1'b0) << 16) | peek16(off + 2, 1'b0);
   endfunction

   // Walks the held file the way the block does and returns the orientation it reports.
   function automatic logic [3:0] predict_orientation();
      longint unsigned size, pos, mark, seg_len, tiff, ifd, n_ent, entry, v;
      bit found, le, be;
      size = held_count;
      pos = 2;
      tiff = 0;
      found = 1'b0;
      if (size < 4 || ((peek8(0) << 8) | peek8(1)) != SOI_WORD) return ORIENT_DEFAULT;
      while (!found && pos + 4 <= size) begin
         if (peek8(pos) != MARK_PREFIX) break;
         mark = peek8(pos + 1);
         if (mark == MARK_SOS || mark == MARK_EOI) break;
         seg_len = peek16(pos + 2, 1'b0);
         if (seg_len < SEG_LEN_MIN || pos + 2 + seg_len > size) break;
         if (mark == MARK_APP1 && seg_len >= APP1_LEN_MIN &&
             peek32(pos + 4, 1'b0) == EXIF_HEAD && peek16(pos + 8, 1'b0) == EXIF_PAD) begin
            found = 1'b1;
            tiff = pos + 10;
         end else begin
            pos += 2 + seg_len;
         end
      end
      if (!found) return ORIENT_DEFAULT;
      le = ((peek8(tiff) << 8) | peek8(tiff + 1)) == BO_LITTLE;
      be = ((peek8(tiff) << 8) | peek8(tiff + 1)) == BO_BIG;
      if (!le && !be) return ORIENT_DEFAULT;
      if (peek16(tiff + 2, le) != TIFF_MAGIC) return ORIENT_DEFAULT;
      ifd = tiff + peek32(tiff + 4, le);
      if (ifd + 2 > size) return ORIENT_DEFAULT;
      n_ent = peek16(ifd, le);
      for (entry = ifd + 2; entry < ifd + 2 + n_ent * ENTRY_BYTES; entry += ENTRY_BYTES) begin
         if (entry + ENTRY_BYTES > size) return ORIENT_DEFAULT;
         if (peek16(entry, le) == ORIENT_TAG && peek16(entry + 2, le) == TYPE_SHORT &&
             peek32(entry + 4, le) == ORIENT_COUNT) begin
            v = peek16(entry + 8, le);
            return (v >= ORIENT_DEFAULT && v <= ORIENT_MAX) ? 4'(v) : ORIENT_DEFAULT;
         end
      end
      return ORIENT_DEFAULT;
   endfunction

   function automatic void put_byte(logic [7:0] b);
      file_q = {file_q, b};
   endfunction

   function automatic void emit16(logic [15:0] v, bit le);
      if (le) begin
         put_byte(v[7:0]);
         put_byte(v[15:8]);
      end else begin
         put_byte(v[15:8]);
         put_byte(v[7:0]);
      end
   endfunction

   function automatic void emit32(logic [31:0] v, bit le);
      if (le) begin
         emit16(v[15:0], 1'b1);
         emit16(v[31:16], 1'b1);
      end else begin
         emit16(v[31:16], 1'b0);
         emit16(v[15:0], 1'b0);
      end
   endfunction

   function automatic exif_spec_type spec_for(tweak_type tweak, logic [15:0] orient);
      exif_spec_type s;
      s.order = BO_LITTLE;
      s.magic = TIFF_MAGIC;
      s.ifd_off = 32'(IFD_NEAR);
      s.n_other = 0;
      s.n_ent = 16'd1;
      s.tag = ORIENT_TAG;
      s.tag_kind = TYPE_SHORT;
      s.tag_count = ORIENT_COUNT;
      s.orient = orient;
      case (tweak)
         T_BIG:       s.order = BO_BIG;
         T_ORDER:     s.order = {BO_LITTLE[15:8], BO_BIG[7:0]};
         T_MAGIC:     s.magic = TIFF_MAGIC + 16'd1;
         T_IFD_FAR:   s.ifd_off = 32'hFFFF_FFF0;
         T_ENTRY_CUT: begin
            // A non-matching first entry and a count that runs past the file.
            s.tag = ORIENT_TAG - 16'd2;
            s.n_ent = 16'd40;
         end
         T_TYPE:      s.tag_kind = TYPE_SHORT + 16'd1;
         T_COUNT:     s.tag_count = ORIENT_COUNT + 32'd1;
         T_OTHERS: begin
            s.n_other = 2;
            s.n_ent = 16'd3;
         end
         default: ;
      endcase
      return s;
   endfunction

   // APP1 segment with the Exif header and a TIFF block whose IFD0 sits right after it.
   function automatic void put_exif(exif_spec_type s);
      bit le;
      int seg_len;
      logic [15:0] t;
      le = (s.order == BO_LITTLE);
      seg_len = 2 + 6 + 8 + 2 + ENTRY_BYTES * (s.n_other + 1) + 4;
      put_byte(MARK_PREFIX);
      put_byte(MARK_APP1);
      emit16(16'(seg_len), 1'b0);
      emit32(EXIF_HEAD, 1'b0);
      emit16(EXIF_PAD, 1'b0);
      emit16(s.order, 1'b0);
      emit16(s.magic, le);
      emit32(s.ifd_off, le);
      emit16(s.n_ent, le);
      repeat (s.n_other) begin
         t = 16'($urandom);
         if (t == ORIENT_TAG) t = t + 16'd1;
         emit16(t, le);
         emit16(16'($urandom_range(0, 7)), le);
         emit32(32'($urandom_range(0, 3)), le);
         emit32($urandom, le);
      end
      emit16(s.tag, le);
      emit16(s.tag_kind, le);
      emit32(s.tag_count, le);
      emit16(s.orient, le);
      emit16(16'h0000, le);
      emit32(32'h0, le);
   endfunction

   function automatic void put_filler();
      int n;
      n = $urandom_range(0, 12);
      put_byte(MARK_PREFIX);
      put_byte(8'($urandom_range(MARK_APP1 + 1, MARK_APP15)));
      emit16(16'(n + 2), 1'b0);
      repeat (n) put_byte(8'($urandom));
   endfunction

   function automatic void build_file(shape_type shape, exif_spec_type s);
      file_q.delete();
      case (shape)
         F_ONE_BYTE: put_byte(MARK_PREFIX);
         F_SHORT: begin
            emit16(SOI_WORD, 1'b0);
            put_byte(MARK_PREFIX);
         end
         F_EOI_ONLY: begin
            emit16(SOI_WORD, 1'b0);
            emit16({MARK_PREFIX, MARK_EOI}, 1'b0);
         end
         F_STORE_FULL: begin
            // One long APP0, then the Exif segment, then bytes past the store size.
            emit16(SOI_WORD, 1'b0);
            emit16({MARK_PREFIX, MARK_APP0}, 1'b0);
            emit16(16'(BIG_SEG), 1'b0);
            repeat (BIG_SEG - 2) put_byte(8'($urandom));
            put_exif(s);
            while (file_q.size() < STORE_BYTES + 4) put_byte(8'($urandom));
         end
         default: begin
            if (shape == F_NO_SOI) emit16({MARK_PREFIX, MARK_EOI}, 1'b0);
            else emit16(SOI_WORD, 1'b0);
            case (shape)
               F_LEN_SMALL: begin
                  emit16({MARK_PREFIX, MARK_APP0}, 1'b0);
                  emit16(SEG_LEN_MIN - 16'd1, 1'b0);
               end
               F_LEN_LONG: begin
                  emit16({MARK_PREFIX, MARK_APP0}, 1'b0);
                  emit16(16'hFFFF, 1'b0);
               end
               F_NOT_MARKER: put_byte(8'h00);
               F_SOS_FIRST: begin
                  emit16({MARK_PREFIX, MARK_SOS}, 1'b0);
                  emit16(16'd4, 1'b0);
                  emit16(16'($urandom), 1'b0);
               end
               F_FILLER: repeat ($urandom_range(1, 2)) put_filler();
               F_APP1_PLAIN: begin
                  emit16({MARK_PREFIX, MARK_APP1}, 1'b0);
                  emit16(APP1_LEN_MIN + 16'd4, 1'b0);
                  repeat (APP1_LEN_MIN + 2) put_byte(8'($urandom));
               end
               F_APP1_SHORT: begin
                  // Exif header present, but the payload is one byte too short.
                  emit16({MARK_PREFIX, MARK_APP1}, 1'b0);
                  emit16(APP1_LEN_MIN - 16'd1, 1'b0);
                  emit32(EXIF_HEAD, 1'b0);
                  emit16(EXIF_PAD, 1'b0);
                  repeat (APP1_LEN_MIN - 9) put_byte(8'($urandom));
               end
               default: ;
            endcase
            put_exif(s);
            emit16({MARK_PREFIX, MARK_EOI}, 1'b0);
         end
      endcase
   endfunction

   function automatic void random_file();
      int r, keep;
      exif_spec_type s;
      shape_type shape;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         file_q.delete();
         if ($urandom_range(0, 1)) emit16(SOI_WORD, 1'b0);
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
         return;
      end
      r = $urandom_range(0, 9);
      if (r < 6) s = spec_for(T_NONE, 16'($urandom_range(1, ORIENT_MAX)));
      else if (r < 8) s = spec_for(T_NONE, 16'($urandom_range(0, 15)));
      else s = spec_for(T_NONE, 16'($urandom));
      if ($urandom_range(0, 1)) s.order = BO_BIG;
      if ($urandom_range(0, 19) == 0) s.order = 16'($urandom);
      if ($urandom_range(0, 19) == 0) s.magic = 16'($urandom_range(40, 44));
      r = $urandom_range(0, 19);
      if (r == 0) s.ifd_off = $urandom_range(0, 48);
      else if (r == 1) s.ifd_off = $urandom;
      s.n_other = $urandom_range(0, 2);
      s.n_ent = 16'(s.n_other + 1);
      if ($urandom_range(0, 9) == 0) s.n_ent = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 12) == 0) s.tag = 16'($urandom);
      if ($urandom_range(0, 12) == 0) s.tag_kind = 16'($urandom_range(0, 7));
      if ($urandom_range(0, 12) == 0) s.tag_count = $urandom_range(0, 3);
      r = $urandom_range(0, 9);
      if (r < 4) shape = F_FILLER;
      else if (r < 7) shape = F_EXIF;
      else if (r == 7) shape = F_APP1_PLAIN;
      else if (r == 8) shape = F_APP1_SHORT;
      else shape = shape_type'($urandom_range(F_ONE_BYTE, F_SOS_FIRST));
      build_file(shape, s);
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1)) emit16({MARK_PREFIX, MARK_SOS}, 1'b0);
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      end
      if ($urandom_range(0, 99) < 12)
         file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 99) < 8) begin
         keep = $urandom_range(1, file_q.size());
         while (file_q.size() > keep) void'(file_q.pop_back());
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Offers file_q word by word and feeds each accepted word that fits the store to the predictor.
   task automatic send_file(input bit gaps_on, input logic [3:0] typed);
      int i, gap;
      bit last;
      logic [3:0] code;
      for (i = 0; i < file_q.size(); i++) begin
         gap = gaps_on ? pick_gap() : 0;
         last = (i == file_q.size() - 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= file_q[i];
         req_last_byte <= last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         if (held_count < STORE_BYTES) begin
            held_bytes[held_count] = file_q[i];
            held_count++;
         end
         if (last) begin
            code = predict_orientation();
            held_count = 0;
            orient_due = {orient_due, (typed != USE_MODEL) ? typed : code};
         end
      end
   endtask

   always @(posedge clock) begin : check_rsp
      logic [3:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         rsp_count++;
         if (orient_due.size() == 0) begin
            $display("%0t: expected no result, got orientation %0d", $time,
                     rsp_orientation_code);
            errors++;
         end else begin
            want = orient_due.pop_front();
            if (rsp_orientation_code !== want) begin
               $display("%0t: orientation expected %0d, got %0d", $time, want,
                        rsp_orientation_code);
               errors++;
            end
         end
      end
   end

   initial begin : drain
      int stall;
      bit held_once;
      held_once = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         // Once, hold off long enough that the block backs up into its input.
         if (!held_once && rsp_count >= HOLD_AFTER) begin
            held_once = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clock);
         else repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   end

   initial begin : stim
      int row, sent_words, sent_files;
      errors = 0;
      rsp_count = 0;
      held_count = 0;
      sent_words = 0;
      sent_files = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < $size(PLAN); row++) begin
         build_file(PLAN[row].shape, spec_for(PLAN[row].tweak, PLAN[row].orient));
         sent_words += file_q.size();
         send_file(PLAN[row].shape != F_STORE_FULL && $urandom_range(0, 3) != 0,
                   PLAN[row].typed);
      end

      while (sent_words < TOTAL_WORDS || sent_files < RANDOM_FILES) begin
         random_file();
         sent_words += file_q.size();
         sent_files++;
         send_file($urandom_range(0, 4) != 0, USE_MODEL);
      end
      req_valid <= 1'b0;

      while (orient_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jef_pkg.sv
hw/rtl/jef_front.sv
hw/rtl/jef_queue.sv
hw/rtl/jef_back.sv
hw/rtl/jpeg_exif_orientation_finder_core.sv
hw/rtl/jef_checker.sv
tb/tb.sv
